// File: hw/rtl/mrg_pkg.sv
// Shared constants, widths and saturation helpers for the maximal rectangle block.
`default_nettype none
package mrg_pkg;

  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 64;

  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int CNT_W  = $clog2(MAX_COLS + 1);
  localparam int HGT_W  = $clog2(MAX_ROWS + 1);
  localparam int AREA_W = HGT_W + CNT_W;
  localparam int ENT_W  = COL_W + HGT_W;

  localparam int CFG_W      = 7;
  localparam int OUT_AREA_W = 13;
  localparam int OUT_HGT_W  = 7;
  localparam int OUT_WID_W  = 7;

  localparam int OUT_AREA_MAX = (1 << OUT_AREA_W) - 1;
  localparam int OUT_HGT_MAX  = (1 << OUT_HGT_W) - 1;
  localparam int OUT_WID_MAX  = (1 << OUT_WID_W) - 1;

  function automatic logic [OUT_AREA_W-1:0] sat_area(input logic [AREA_W-1:0] a);
    if (32'(a) > 32'(OUT_AREA_MAX)) begin
      return OUT_AREA_W'(OUT_AREA_MAX);
    end
    return OUT_AREA_W'(a);
  endfunction

  function automatic logic [OUT_HGT_W-1:0] sat_hgt(input logic [HGT_W-1:0] h);
    if (32'(h) > 32'(OUT_HGT_MAX)) begin
      return OUT_HGT_W'(OUT_HGT_MAX);
    end
    return OUT_HGT_W'(h);
  endfunction

  function automatic logic [OUT_WID_W-1:0] sat_wid(input logic [CNT_W-1:0] w);
    if (32'(w) > 32'(OUT_WID_MAX)) begin
      return OUT_WID_W'(OUT_WID_MAX);
    end
    return OUT_WID_W'(w);
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/mrg_in_if.sv
// Grid cell channel: one cell per beat.
`default_nettype none
interface mrg_in_if;
  logic valid;
  logic ready;
  logic cell_open;
  logic first_row;

  modport source (output valid, output cell_open, output first_row, input ready);
  modport sink   (input valid, input cell_open, input first_row, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/mrg_out_if.sv
// Row result channel: one rectangle per beat.
`default_nettype none
interface mrg_out_if;
  logic        valid;
  logic        ready;
  logic [12:0] row_max_area;
  logic [6:0]  rect_height;
  logic [6:0]  rect_width;

  modport source (output valid, output row_max_area, output rect_height, output rect_width,
                  input ready);
  modport sink   (input valid, input row_max_area, input rect_height, input rect_width,
                  output ready);
endinterface
`default_nettype wire

// File: hw/rtl/mrg_ram.sv
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module mrg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/maximal_rectangle_in_grid.sv
// Top level: largest all-open rectangle per grid row, histogram stack scan.
//
// Cells arrive on grid, one per beat, in row-major order. num_cols is set
// through cfg_we/cfg_wdata (reset value 64); the user must write it only
// while the block is idle, which the block itself does not enforce. Each
// column keeps a running height of open cells in a small RAM. A cell that
// is not the last of its row is handled as a height read, then a write
// back; grid.ready is low meanwhile. The last cell of a row also starts
// the stack scan: column read and compare per push; compare, read of the
// entry below and score per pop. The scan is bound by the single height
// RAM read port and the stack RAM's one write and one read port, used one
// step at a time by the sequencer. One beat leaves on rect per row. The
// result sits in an output register: the block takes the next cells while
// it waits; if the next row ends before rect is taken, the block holds the
// new result and stays busy. Reset (rst, synchronous) zeroes all column
// heights through per-column valid bits, so there is no clearing pass, and
// empties both channels.
`default_nettype none
module maximal_rectangle_in_grid
  import mrg_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  mrg_in_if.sink                grid,
  mrg_out_if.source             rect
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_RDCOL,
    S_CMP,
    S_POP,
    S_POP2,
    S_DRAIN
  } state_t;

  state_t state;

  logic [CFG_W-1:0]  num_cols;
  logic [COL_W-1:0]  column_pos;
  logic [COL_W-1:0]  pos_r;
  logic              open_r;
  logic              first_r;
  logic              last_r;
  logic [MAX_COLS-1:0] hvalid;
  logic              hv_rd;

  logic [CNT_W-1:0]  col;
  logic [CNT_W-1:0]  depth;
  logic [HGT_W-1:0]  top_h;
  logic [AREA_W-1:0] best_area;
  logic [HGT_W-1:0]  best_height;
  logic [CNT_W-1:0]  best_width;

  logic                  out_valid;
  logic                  out_load;
  logic [OUT_AREA_W-1:0] out_area;
  logic [OUT_HGT_W-1:0]  out_height;
  logic [OUT_WID_W-1:0]  out_width;

  logic [CNT_W-1:0]  ncols;
  logic [COL_W-1:0]  pos_eff;
  logic              accept;
  logic              is_last;

  logic              hram_we;
  logic              hram_re;
  logic [COL_W-1:0]  hram_raddr;
  logic [HGT_W-1:0]  hram_rdata;
  logic [HGT_W-1:0]  h_rd;
  logic [HGT_W-1:0]  h_new;

  logic              sram_we;
  logic              sram_re;
  logic [COL_W-1:0]  sram_raddr;
  logic [ENT_W-1:0]  sram_wdata;
  logic [ENT_W-1:0]  sram_rdata;
  logic [COL_W-1:0]  st_idx;
  logic [HGT_W-1:0]  st_h;

  logic              push;
  logic [CNT_W-1:0]  pop_w;
  logic [AREA_W-1:0] pop_area;

  always_comb begin
    if (num_cols == '0) begin
      ncols = CNT_W'(1);
    end else if (32'(num_cols) > 32'(MAX_COLS)) begin
      ncols = CNT_W'(MAX_COLS);
    end else begin
      ncols = CNT_W'(num_cols);
    end
  end

  // a position left beyond a shrunk row ends the row at its last column
  always_comb begin
    if (CNT_W'(column_pos) >= ncols) begin
      pos_eff = COL_W'(ncols - CNT_W'(1));
    end else begin
      pos_eff = column_pos;
    end
  end

  assign accept     = grid.valid && grid.ready;
  assign grid.ready = (state == S_IDLE);
  assign is_last    = (CNT_W'(pos_eff) + CNT_W'(1)) >= ncols;

  // column heights
  assign hram_re    = accept || (state == S_RDCOL);
  assign hram_raddr = (state == S_IDLE) ? pos_eff : col[COL_W-1:0];
  assign hram_we    = (state == S_UPD);
  assign h_rd       = hv_rd ? hram_rdata : '0;

  always_comb begin
    if (!open_r) begin
      h_new = '0;
    end else if (first_r) begin
      h_new = HGT_W'(1);
    end else if (32'(h_rd) < 32'(MAX_ROWS)) begin
      h_new = h_rd + HGT_W'(1);
    end else begin
      h_new = HGT_W'(MAX_ROWS);
    end
  end

  mrg_ram #(
    .WIDTH (HGT_W),
    .DEPTH (MAX_COLS)
  ) u_heights (
    .clk   (clk),
    .we    (hram_we),
    .waddr (pos_r),
    .wdata (h_new),
    .re    (hram_re),
    .raddr (hram_raddr),
    .rdata (hram_rdata)
  );

  // index stack, each entry carries its column height too
  assign push       = (depth == '0) || (top_h <= h_rd);
  assign sram_we    = (state == S_CMP) && push;
  assign sram_wdata = {col[COL_W-1:0], h_rd};
  assign sram_re    = (state == S_POP) && (depth > CNT_W'(1));
  assign sram_raddr = COL_W'(depth - CNT_W'(2));
  assign st_idx     = sram_rdata[ENT_W-1:HGT_W];
  assign st_h       = sram_rdata[HGT_W-1:0];

  mrg_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_COLS)
  ) u_stack (
    .clk   (clk),
    .we    (sram_we),
    .waddr (depth[COL_W-1:0]),
    .wdata (sram_wdata),
    .re    (sram_re),
    .raddr (sram_raddr),
    .rdata (sram_rdata)
  );

  // depth is already decremented here; an empty stack means width is col
  assign pop_w    = (depth == '0) ? col : (col - CNT_W'(st_idx) - CNT_W'(1));
  assign pop_area = AREA_W'(top_h) * AREA_W'(pop_w);

  // scan done and the output register free or emptied this cycle
  assign out_load = (state == S_DRAIN) && (depth == '0) && (!out_valid || rect.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      num_cols   <= CFG_W'(64);
      column_pos <= '0;
      hvalid     <= '0;
      hv_rd      <= 1'b0;
      depth      <= '0;
      col        <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        num_cols <= cfg_wdata;
      end
      if (hram_re) begin
        hv_rd <= hvalid[hram_raddr];
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rect.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            open_r     <= grid.cell_open;
            first_r    <= grid.first_row;
            pos_r      <= pos_eff;
            last_r     <= is_last;
            column_pos <= is_last ? '0 : (pos_eff + COL_W'(1));
            state      <= S_UPD;
          end
        end
        S_UPD: begin
          hvalid[pos_r] <= 1'b1;
          if (last_r) begin
            col         <= '0;
            depth       <= '0;
            best_area   <= '0;
            best_height <= HGT_W'(1);
            best_width  <= '0;
            state       <= S_RDCOL;
          end else begin
            state <= S_IDLE;
          end
        end
        S_RDCOL: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (push) begin
            top_h   <= h_rd;
            depth   <= depth + CNT_W'(1);
            col     <= col + CNT_W'(1);
            state   <= ((col + CNT_W'(1)) < ncols) ? S_RDCOL : S_DRAIN;
          end else begin
            state <= S_POP;
          end
        end
        S_POP: begin
          depth <= depth - CNT_W'(1);
          state <= S_POP2;
        end
        S_POP2: begin
          // only a strictly larger area replaces the best
          if (pop_area > best_area) begin
            best_area   <= pop_area;
            best_height <= top_h;
            best_width  <= pop_w;
          end
          if (depth != '0) begin
            top_h   <= st_h;
          end
          state <= (col < ncols) ? S_CMP : S_DRAIN;
        end
        S_DRAIN: begin
          if (depth != '0) begin
            state <= S_POP;
          end else if (out_load) begin
            out_area   <= sat_area(best_area);
            out_height <= sat_hgt(best_height);
            out_width  <= sat_wid(best_width);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rect.valid        = out_valid;
  assign rect.row_max_area = out_area;
  assign rect.rect_height  = out_height;
  assign rect.rect_width   = out_width;

`ifndef SYNTH
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= CNT_W'(MAX_COLS))
    else $error("stack depth beyond column count");

  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP || state == S_RDCOL) |-> col < ncols)
    else $error("scan column past row end");

  a_accept_upd: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_UPD)
    else $error("accepted cell not written back");

  a_zero_area: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_area == '0) |-> (out_height == OUT_HGT_W'(1) && out_width == '0))
    else $error("empty rectangle with nonzero shape");

  a_area_prod: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN && depth == '0) |->
      best_area == AREA_W'(AREA_W'(best_height) * AREA_W'(best_width)) || best_area == '0)
    else $error("best area does not match its shape");
`endif

endmodule
`default_nettype wire

// File: tb/tb_maximal_rectangle_in_grid.sv
// Self-checking testbench for maximal_rectangle_in_grid: directed table, random grids, predictor.
module tb_maximal_rectangle_in_grid;
  import mrg_pkg::*;

  localparam int SETTLE_CYCLES = 5 * MAX_COLS + 40;  // worst row scan plus margin
  localparam int STALL_LIMIT   = 4000;
  localparam int RANDOM_CELLS  = 1500;
  localparam int IDLE_PCT      = 29;

  typedef struct packed {
    logic [OUT_AREA_W-1:0] area;
    logic [OUT_HGT_W-1:0]  height;
    logic [OUT_WID_W-1:0]  width;
  } rect_t;

  typedef enum logic {STEP_CFG, STEP_CELL} step_kind_t;

  typedef struct packed {
    step_kind_t       kind;
    logic [CFG_W-1:0] cols;
    logic             open;
    logic             first;
    logic             typed;
    rect_t            want;
  } step_t;

  localparam rect_t NONE = '0;

  // typed results only where obvious; the rest come from the predictor
  localparam step_t DIRECTED [30] = '{
    '{STEP_CFG,  7'd1, 1'b0, 1'b0, 1'b0, NONE},
    '{STEP_CELL, 7'd0, 1'b1, 1'b1, 1'b1, '{13'd1, 7'd1, 7'd1}},
    '{STEP_CELL, 7'd0, 1'b1, 1'b0, 1'b1, '{13'd2, 7'd2, 7'd1}},
    '{STEP_CELL, 7'd0, 1'b0, 1'b0, 1'b1, '{13'd0, 7'd1, 7'd0}},
    '{STEP_CFG,  7'd0, 1'b0, 1'b0, 1'b0, NONE},   // zero columns acts as one
    '{STEP_CELL, 7'd0, 1'b1, 1'b0, 1'b1, '{13'd1, 7'd1, 7'd1}},
    '{STEP_CFG,  7'd3, 1'b0, 1'b0, 1'b0, NONE},
    '{STEP_CELL, 7'd0, 1'b1, 1'b1, 1'b0, NONE},
    '{STEP_CELL, 7'd0, 1'b1, 1'b1, 1'b0, NONE},
    '{STEP_CELL, 7'd0, 1'b1, 1'b1, 1'b1, '{13'd3, 7'd1, 7'd3}},
    '{STEP_CELL, 7'd0, 1'b1, 1'b0, 1'b0, NONE},
    '{STEP_CELL, 7'd0, 1'b0, 1'b0, 1'b0, NONE},
    '{STEP_CELL, 7'd0, 1'b1, 1'b0, 1'b1, '{13'd2, 7'd2, 7'd1}},
    '{STEP_CELL, 7'd0, 1'b1, 1'b0, 1'b0, NONE},
    '{STEP_CELL, 7'd0, 1'b1, 1'b1, 1'b0, NONE},   // first-row flag inside a row
    '{STEP_CFG,  7'd1, 1'b0, 1'b0, 1'b0, NONE},   // shrink mid-row: next cell ends it
    '{STEP_CELL, 7'd0, 1'b1, 1'b0, 1'b0, NONE},
    '{STEP_CFG,  7'd4, 1'b0, 1'b0, 1'b0, NONE},
    '{STEP_CELL, 7'd0, 1'b1, 1'b1, 1'b0, NONE},
    '{STEP_CELL, 7'd0, 1'b1, 1'b1, 1'b0, NONE},
    '{STEP_CELL, 7'd0, 1'b1, 1'b1, 1'b0, NONE},
    '{STEP_CELL, 7'd0, 1'b1, 1'b1, 1'b0, NONE},
    '{STEP_CELL, 7'd0, 1'b1, 1'b0, 1'b0, NONE},
    '{STEP_CELL, 7'd0, 1'b1, 1'b0, 1'b0, NONE},
    '{STEP_CELL, 7'd0, 1'b1, 1'b0, 1'b0, NONE},
    '{STEP_CELL, 7'd0, 1'b0, 1'b0, 1'b0, NONE},
    '{STEP_CELL, 7'd0, 1'b0, 1'b0, 1'b0, NONE},
    '{STEP_CELL, 7'd0, 1'b1, 1'b0, 1'b0, NONE},
    '{STEP_CELL, 7'd0, 1'b1, 1'b0, 1'b0, NONE},
    '{STEP_CELL, 7'd0, 1'b1, 1'b0, 1'b0, NONE}
  };

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  mrg_in_if  grid_if ();
  mrg_out_if rect_if ();

  maximal_rectangle_in_grid DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .grid      (grid_if),
    .rect      (rect_if)
  );

  // predictor state
  logic [HGT_W-1:0] col_height [MAX_COLS];
  int unsigned      next_col;
  logic [CFG_W-1:0] cols_setting;

  rect_t pending_rects [$];
  rect_t front_rect;
  int    errors;
  int    stall_cycles;
  bit    idle_on;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned cols_in_use(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (int'(v) > MAX_COLS) return MAX_COLS;
    return 32'(v);
  endfunction

  // Update the column heights for one cell; on the last cell of a row, run the
  // monotonic stack scan and return the best rectangle with bottom on that row.
  function automatic bit row_rectangle(input bit open, input bit first, output rect_t res);
    int unsigned ncols, pos, col, depth, top, h, w, a, best_a, best_h, best_w;
    int unsigned stk [MAX_COLS];
    ncols = cols_in_use(cols_setting);
    pos = (next_col >= ncols) ? ncols - 1 : next_col;
    if (!open) h = 0;
    else if (first) h = 1;
    else h = (col_height[pos] < MAX_ROWS) ? col_height[pos] + 1 : MAX_ROWS;
    col_height[pos] = HGT_W'(h);
    res = NONE;
    if (pos + 1 < ncols) begin
      next_col = pos + 1;
      return 1'b0;
    end
    next_col = 0;
    col = 0;
    depth = 0;
    best_a = 0;
    best_h = 1;
    best_w = 0;
    while (col < ncols || depth != 0) begin
      if (col < ncols && (depth == 0 || col_height[stk[depth-1]] <= col_height[col])) begin
        stk[depth] = col;
        depth++;
        col++;
      end else begin
        depth--;
        top = stk[depth];
        h = col_height[top];
        w = (depth == 0) ? col : col - stk[depth-1] - 1;
        a = h * w;
        if (a > best_a) begin
          best_a = a;
          best_h = h;
          best_w = w;
        end
      end
    end
    res.area   = (best_a > OUT_AREA_MAX) ? OUT_AREA_W'(OUT_AREA_MAX) : OUT_AREA_W'(best_a);
    res.height = (best_h > OUT_HGT_MAX) ? OUT_HGT_W'(OUT_HGT_MAX) : OUT_HGT_W'(best_h);
    res.width  = (best_w > OUT_WID_MAX) ? OUT_WID_W'(OUT_WID_MAX) : OUT_WID_W'(best_w);
    return 1'b1;
  endfunction

  task automatic send_cell(input bit open, input bit first, input bit typed, input rect_t want);
    rect_t got;
    if (idle_on && $urandom_range(99) < IDLE_PCT) begin
      grid_if.valid <= 1'b0;
      do @(posedge clk); while (idle_on && $urandom_range(99) < IDLE_PCT);
    end
    grid_if.valid     <= 1'b1;
    grid_if.cell_open <= open;
    grid_if.first_row <= first;
    do @(posedge clk); while (!grid_if.ready);
    if (row_rectangle(open, first, got)) begin
      pending_rects.insert(pending_rects.size(), typed ? want : got);
    end
  endtask

  // drop valid, wait for every row result, then let the block finish any cell in flight
  task automatic settle();
    grid_if.valid <= 1'b0;
    while (pending_rects.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cols(input logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we       <= 1'b0;
    cols_setting = v;
  endtask

  // result checker and ready generator
  always @(posedge clk) begin
    if (!rst && rect_if.valid && rect_if.ready) begin
      if (pending_rects.size() == 0) begin
        $display("%0t: unexpected result, expected none, got area %0d height %0d width %0d",
                 $time, rect_if.row_max_area, rect_if.rect_height, rect_if.rect_width);
        errors++;
      end else begin
        front_rect = pending_rects.pop_front();
        if (rect_if.row_max_area !== front_rect.area) begin
          $display("%0t: row_max_area expected %0d, got %0d",
                   $time, front_rect.area, rect_if.row_max_area);
          errors++;
        end
        if (rect_if.rect_height !== front_rect.height) begin
          $display("%0t: rect_height expected %0d, got %0d",
                   $time, front_rect.height, rect_if.rect_height);
          errors++;
        end
        if (rect_if.rect_width !== front_rect.width) begin
          $display("%0t: rect_width expected %0d, got %0d",
                   $time, front_rect.width, rect_if.rect_width);
          errors++;
        end
      end
    end
    rect_if.ready <= idle_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
  end

  // watchdog: cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst || (grid_if.valid && grid_if.ready) || (rect_if.valid && rect_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, stall_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int unsigned      rand_cells, ncols, rows, open_pct, extra;
    bit               tall, new_grid, cell_o, cell_f;
    logic [CFG_W-1:0] cols_val;
    int               pick;

    clk               = 1'b0;
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    grid_if.valid     = 1'b0;
    grid_if.cell_open = 1'b0;
    grid_if.first_row = 1'b0;
    rect_if.ready     = 1'b0;
    errors            = 0;
    stall_cycles      = 0;
    idle_on           = 1'b1;
    foreach (col_height[i]) col_height[i] = '0;
    next_col     = 0;
    cols_setting = CFG_W'(MAX_COLS);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == STEP_CFG) begin
        settle();
        write_cols(DIRECTED[i].cols);
      end else begin
        send_cell(DIRECTED[i].open, DIRECTED[i].first, DIRECTED[i].typed, DIRECTED[i].want);
      end
    end

    rand_cells = 0;
    while (rand_cells < RANDOM_CELLS) begin
      idle_on = !(rand_cells >= 500 && rand_cells < 800);  // quiet stretch
      tall = ($urandom_range(7) == 0);
      pick = $urandom_range(99);
      if (tall) cols_val = CFG_W'($urandom_range(1, 2));
      else if (pick < 8) cols_val = '0;
      else if (pick < 16) cols_val = CFG_W'(MAX_COLS);
      else if (pick < 22) cols_val = CFG_W'($urandom_range(MAX_COLS + 1, 127));
      else if (pick < 30) cols_val = CFG_W'($urandom_range(9, MAX_COLS - 1));
      else cols_val = CFG_W'($urandom_range(1, 8));
      settle();
      write_cols(cols_val);
      ncols = cols_in_use(cols_val);
      case ($urandom_range(2))
        0: open_pct = 50;
        1: open_pct = 80;
        default: open_pct = 95;
      endcase
      if (tall) begin
        open_pct = 100;
        rows = MAX_ROWS + 6;  // drives heights into saturation
      end else begin
        rows = (ncols > 16) ? $urandom_range(1, 3) : $urandom_range(2, 12);
      end
      new_grid = tall || ($urandom_range(3) != 0);
      for (int unsigned r = 0; r < rows; r++) begin
        for (int unsigned c = 0; c < ncols; c++) begin
          cell_o = ($urandom_range(99) < open_pct);
          cell_f = new_grid;
          if ($urandom_range(99) < 3) cell_f = !cell_f;  // stray first-row flags
          send_cell(cell_o, cell_f, 1'b0, NONE);
          rand_cells++;
        end
        new_grid = !tall && ($urandom_range(9) == 0);
      end
      // leave a partial row so the next setting lands mid-row
      if (ncols > 1 && $urandom_range(4) == 0) begin
        extra = $urandom_range(1, ncols - 1);
        repeat (extra) begin
          send_cell(1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, NONE);
          rand_cells++;
        end
      end
    end

    settle();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
